[rtl/lpfs_pkg.sv]
// Shared types and constants for the length-prefixed frame splitter.
// No dependencies; every other file of the block imports this package.
package lpfs_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned IDX_W        = $clog2(HEADER_BYTES);
    localparam int unsigned MAX_LEN_W    = 19;
    localparam int unsigned REM_W        = 18;
    localparam int unsigned ADDR_W       = 32;

    localparam logic [MAX_LEN_W-1:0] LEN_CEILING = MAX_LEN_W'(1024 * 256);
    localparam logic [ADDR_W-1:0]    MIN_LEN     = ADDR_W'(8);
    localparam logic [ADDR_W-1:0]    CMD_ADDRESS = 32'hFFFF_FFFF;
    localparam logic [IDX_W-1:0]     IDX_LAST    = IDX_W'(HEADER_BYTES - 1);

    // configuration register indexes
    localparam logic CFG_ACCEPT_ENABLE = 1'b0;
    localparam logic CFG_MAX_LEN       = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ADDRESS,
        PH_PAYLOAD,
        PH_HALTED
    } t_phase;

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic              frame_kind;
        logic [ADDR_W-1:0] route_address;
        logic              last_of_frame;
        logic              length_error;
    } t_result;

endpackage

[rtl/lpfs_parser.sv]
// Input register and frame parsing state machine of the frame splitter.
// Depends on lpfs_pkg; feeds lpfs_out_reg.
module lpfs_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_ready,
    input  logic                          i_accept_enable,
    input  logic [lpfs_pkg::MAX_LEN_W-1:0] i_max_len,
    input  logic                          i_down_ready,
    output logic                          o_res_valid,
    output lpfs_pkg::t_result             o_res
);
    import lpfs_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    t_phase               r_phase, n_phase;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [23:0]          r_len, n_len;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [REM_W-1:0]     r_rem, n_rem;

    logic                 adv;
    logic                 step;
    logic                 idx_end;
    logic [ADDR_W-1:0]    len_full;
    logic [MAX_LEN_W-1:0] limit;
    logic                 len_bad;
    logic                 last;

    assign adv     = r_in_valid && i_down_ready;
    assign step    = adv && i_accept_enable;
    assign o_ready = !r_in_valid || adv;

    assign idx_end  = (r_idx == IDX_LAST);
    assign len_full = {r_in_byte, r_len};
    assign limit    = (i_max_len > LEN_CEILING) ? LEN_CEILING : i_max_len;
    assign len_bad  = (len_full < MIN_LEN) || (len_full > ADDR_W'(limit));
    assign last     = (r_rem <= REM_W'(1));

    // next state
    always_comb begin
        n_phase = r_phase;
        if (step) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (idx_end) n_phase = len_bad ? PH_HALTED : PH_ADDRESS;
                end
                PH_ADDRESS: begin
                    if (idx_end) n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (last) n_phase = PH_HEADER;
                end
                PH_HALTED: begin
                    n_phase = PH_HALTED;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_idx       = r_idx;
        n_len       = r_len;
        n_addr      = r_addr;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (step) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_idx = r_idx + IDX_W'(1);
                    unique case (r_idx)
                        2'd0:    n_len[7:0]   = r_in_byte;
                        2'd1:    n_len[15:8]  = r_in_byte;
                        2'd2:    n_len[23:16] = r_in_byte;
                        default: n_len        = r_len;
                    endcase
                    if (idx_end) begin
                        n_idx = '0;
                        n_rem = len_full[REM_W-1:0] - REM_W'(4);
                        if (len_bad) begin
                            o_res_valid        = 1'b1;
                            o_res.length_error = 1'b1;
                        end
                    end
                end
                PH_ADDRESS: begin
                    n_idx = idx_end ? '0 : r_idx + IDX_W'(1);
                    unique case (r_idx)
                        2'd0:    n_addr[7:0]   = r_in_byte;
                        2'd1:    n_addr[15:8]  = r_in_byte;
                        2'd2:    n_addr[23:16] = r_in_byte;
                        default: n_addr[31:24] = r_in_byte;
                    endcase
                end
                PH_PAYLOAD: begin
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = r_in_byte;
                    o_res.frame_kind    = (r_addr == CMD_ADDRESS);
                    o_res.route_address = r_addr;
                    o_res.last_of_frame = last;
                    n_rem = last ? '0 : r_rem - REM_W'(1);
                end
                default: begin
                    n_idx = r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HEADER;
            r_idx      <= '0;
            r_rem      <= '0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
        end
    end

    // hold the beat until the result side can take it
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_data_byte;
        r_len  <= n_len;
        r_addr <= n_addr;
    end

endmodule

[rtl/lpfs_out_reg.sv]
// Result register of the frame splitter with valid/ready toward the sink.
// Depends on lpfs_pkg for the result struct.
module lpfs_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpfs_pkg::t_result i_res,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output lpfs_pkg::t_result o_res
);
    import lpfs_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) r_res <= i_res;
    end

endmodule

[rtl/length_prefixed_frame_splitter.sv]
// Top level of the length-prefixed frame splitter: configuration registers,
// parser and result register. Depends on lpfs_pkg, lpfs_parser, lpfs_out_reg.
//
// One received byte per beat. A frame is a 4-byte little-endian length
// (8 to max_frame_length, capped at 262144), a 4-byte little-endian route
// address (all ones = command frame) and length-4 payload bytes, each of
// which leaves as one result beat. Header and address bytes give no result;
// a bad length gives one error beat and then every byte is dropped until
// reset. With accept_enable low bytes are taken and dropped. Each byte
// passes the input and then the result register; the block sustains one
// byte per cycle while i_ready is high. The result register can hold a
// beat while the next byte is accepted. Write configuration only while idle.
module length_prefixed_frame_splitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_frame_kind,
    output logic [lpfs_pkg::ADDR_W-1:0]    o_route_address,
    output logic                           o_last_of_frame,
    output logic                           o_length_error,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_index,
    input  logic [lpfs_pkg::MAX_LEN_W-1:0] i_cfg_data
);
    import lpfs_pkg::*;

    logic                 r_accept_enable;
    logic [MAX_LEN_W-1:0] r_max_len;
    logic                 res_valid;
    logic                 can_load;
    t_result              res;
    t_result              out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_enable <= 1'b1;
            r_max_len       <= LEN_CEILING;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACCEPT_ENABLE: r_accept_enable <= i_cfg_data[0];
                CFG_MAX_LEN:       r_max_len       <= i_cfg_data;
                default:           r_max_len       <= r_max_len;
            endcase
        end
    end

    lpfs_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .o_ready         (o_ready),
        .i_accept_enable (r_accept_enable),
        .i_max_len       (r_max_len),
        .i_down_ready    (can_load),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    lpfs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_kind    = out_res.frame_kind;
    assign o_route_address = out_res.route_address;
    assign o_last_of_frame = out_res.last_of_frame;
    assign o_length_error  = out_res.length_error;

endmodule

[tb/length_prefixed_frame_splitter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_frame_splitter: a scoreboard class
// tracks the frame parser state and checks every payload and error beat.
// Depends on lpfs_pkg and the length_prefixed_frame_splitter RTL.
module length_prefixed_frame_splitter_tb;
    import lpfs_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 1000;
    localparam int PHASE_COUNT   = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PERCENT  = 21;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_ALL_ONES = '1;

    typedef enum int {
        BAD_SHORT,
        BAD_LONG,
        BAD_TINY_MAX,
        BAD_OVER_CEILING
    } t_bad_case;

    class frame_scoreboard;
        logic                 accept_en;
        logic [MAX_LEN_W-1:0] max_len;
        t_phase               phase;
        logic [IDX_W-1:0]     idx;
        logic [31:0]          len_acc;
        logic [ADDR_W-1:0]    addr_acc;
        logic [REM_W-1:0]     remaining;
        t_result              expected_q[$];
        int                   mismatches;

        function new();
            accept_en  = 1'b1;
            max_len    = LEN_CEILING;
            phase      = PH_HEADER;
            idx        = '0;
            len_acc    = '0;
            addr_acc   = '0;
            remaining  = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic index, logic [MAX_LEN_W-1:0] value);
            if (index == CFG_ACCEPT_ENABLE) begin
                accept_en = value[0];
            end else begin
                max_len = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Returns 1 when the byte entered the parser, 0 when it was dropped.
        function bit take_byte(logic [7:0] b);
            logic [MAX_LEN_W-1:0] lim;
            logic                 last;
            if (!accept_en || phase == PH_HALTED) begin
                return 1'b0;
            end
            case (phase)
                PH_HEADER: begin
                    if (idx == '0) begin
                        len_acc = '0;
                    end
                    len_acc[idx*8 +: 8] = b;
                    if (idx != IDX_LAST) begin
                        idx++;
                    end else begin
                        idx = '0;
                        lim = (max_len > LEN_CEILING) ? LEN_CEILING : max_len;
                        if (len_acc < MIN_LEN || len_acc > lim) begin
                            phase = PH_HALTED;
                            expected_q.push_back(t_result'{payload_byte: 8'h00,
                                frame_kind: 1'b0, route_address: '0,
                                last_of_frame: 1'b0, length_error: 1'b1});
                        end else begin
                            remaining = REM_W'(len_acc - 4);
                            addr_acc  = '0;
                            phase     = PH_ADDRESS;
                        end
                    end
                end
                PH_ADDRESS: begin
                    addr_acc[idx*8 +: 8] = b;
                    if (idx != IDX_LAST) begin
                        idx++;
                    end else begin
                        idx   = '0;
                        phase = PH_PAYLOAD;
                    end
                end
                default: begin
                    last = (remaining <= 1);
                    expected_q.push_back(t_result'{payload_byte: b,
                        frame_kind: (addr_acc == CMD_ADDRESS), route_address: addr_acc,
                        last_of_frame: last, length_error: 1'b0});
                    if (last) begin
                        remaining = '0;
                        phase     = PH_HEADER;
                        idx       = '0;
                    end else begin
                        remaining--;
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, exp_v,
                             got_v);
                end
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected beat: byte 0x%0h addr 0x%0h last %0b err %0b",
                             got.payload_byte, got.route_address, got.last_of_frame,
                             got.length_error);
                end
                return;
            end
            want = expected_q.pop_front();
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
            compare_field("route_address", want.route_address, got.route_address);
            compare_field("last_of_frame", 32'(want.last_of_frame),
                          32'(got.last_of_frame));
            compare_field("length_error", 32'(want.length_error), 32'(got.length_error));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_data_byte = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [7:0]           o_payload_byte;
    logic                 o_frame_kind;
    logic [ADDR_W-1:0]    o_route_address;
    logic                 o_last_of_frame;
    logic                 o_length_error;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_index = CFG_ACCEPT_ENABLE;
    logic [MAX_LEN_W-1:0] i_cfg_data = '0;

    frame_scoreboard sb;
    int              bytes_taken = 0;
    int              cycle_count = 0;
    bit              calm = 1'b0;

    length_prefixed_frame_splitter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_payload_byte  (o_payload_byte),
        .o_frame_kind    (o_frame_kind),
        .o_route_address (o_route_address),
        .o_last_of_frame (o_last_of_frame),
        .o_length_error  (o_length_error),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: stall at random, except during the calm stretch.
    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_beat(t_result'{payload_byte: o_payload_byte,
                frame_kind: o_frame_kind, route_address: o_route_address,
                last_of_frame: o_last_of_frame, length_error: o_length_error});
        end
    end

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        if (sb.take_byte(b)) begin
            bytes_taken++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            send_byte(w[i*8 +: 8]);
        end
    endtask

    task automatic send_frame(input logic [31:0] len, input logic [ADDR_W-1:0] addr);
        send_word(len);
        send_word(addr);
        for (int i = 0; i < int'(len) - 4; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold the sender until every expected beat is out, then let the pipe empty.
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [MAX_LEN_W-1:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        sb.set_reg(index, value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Disable reception, push garbage that must vanish, then re-enable.
    task automatic drop_noise(input int count);
        drain();
        write_reg(CFG_ACCEPT_ENABLE, MAX_LEN_W'(0));
        repeat (count) send_byte(8'($urandom_range(0, 255)));
        drain();
        write_reg(CFG_ACCEPT_ENABLE, MAX_LEN_W'(1));
    endtask

    task automatic random_frames(input int target);
        logic [MAX_LEN_W-1:0] lim;
        logic [31:0]          len;
        logic [ADDR_W-1:0]    addr;
        int                   roll;
        while (bytes_taken < target) begin
            lim  = (sb.max_len > LEN_CEILING) ? LEN_CEILING : sb.max_len;
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len = 8 + $urandom_range(0, 8);
            end else if (roll < 95) begin
                len = 17 + $urandom_range(0, 47);
            end else begin
                len = 65 + $urandom_range(0, 235);
            end
            if (len > lim || (lim <= 400 && $urandom_range(0, 9) == 0)) begin
                len = 32'(lim);
            end
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                addr = CMD_ADDRESS;
            end else if (roll < 35) begin
                addr = '0;
            end else begin
                addr = $urandom;
            end
            if ($urandom_range(0, 99) < 3) begin
                drain();
            end
            send_frame(len, addr);
        end
    endtask

    initial begin
        logic [MAX_LEN_W-1:0] phase_max;
        logic [MAX_LEN_W-1:0] bad_max;
        logic [31:0]          bad_len;
        t_bad_case            bad_case;
        int                   target;

        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Shortest command frame with extreme payload values.
        send_word(32'd8);
        send_word(CMD_ADDRESS);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);

        // Disable in the middle of the address; state must survive the noise.
        send_word(32'd9);
        send_byte(8'h00);
        send_byte(8'h00);
        drop_noise(12);
        send_byte(8'h00);
        send_byte(8'h00);
        repeat (5) send_byte(8'($urandom_range(0, 255)));

        target = bytes_taken;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0:       phase_max = LEN_CEILING;
                1:       phase_max = MAX_LEN_W'(8);
                2:       phase_max = MAX_LEN_W'($urandom_range(9, 64));
                3:       phase_max = MAX_LEN_ALL_ONES;
                4:       phase_max = MAX_LEN_W'($urandom_range(9, 400));
                default: phase_max = LEN_CEILING;
            endcase
            drain();
            write_reg(CFG_MAX_LEN, phase_max);
            if ($urandom_range(0, 99) < 40) begin
                drop_noise($urandom_range(5, 30));
            end
            calm   = (ph == 2);
            target = target + RANDOM_BYTES / PHASE_COUNT;
            random_frames(target);
        end
        calm = 1'b0;

        // One bad header ends parsing for good; pick which way it is bad.
        drain();
        bad_case = t_bad_case'($urandom_range(0, 3));
        case (bad_case)
            BAD_SHORT: begin
                bad_len = $urandom_range(0, 7);
            end
            BAD_LONG: begin
                bad_max = MAX_LEN_W'($urandom_range(8, 300));
                write_reg(CFG_MAX_LEN, bad_max);
                bad_len = $urandom_range(0, 1) ? 32'(bad_max) + 1 : 32'hFFFF_FFFF;
            end
            BAD_TINY_MAX: begin
                write_reg(CFG_MAX_LEN, MAX_LEN_W'($urandom_range(0, 7)));
                bad_len = 32'd8;
            end
            default: begin
                write_reg(CFG_MAX_LEN, MAX_LEN_ALL_ONES);
                bad_len = 32'(LEN_CEILING) + 1;
            end
        endcase
        send_word(bad_len);
        repeat (30) send_byte(8'($urandom_range(0, 255)));
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
